// File: rtl/core/slc_pkg.sv
// shared constants and types of the set-associative write-back cache
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

	localparam int NUM_SETS        = 2;
	localparam int NUM_WAYS        = 4;
	localparam int WORDS_PER_BLOCK = 2;

	localparam int ADDR_W = 32;
	localparam int WORD_W = $clog2(WORDS_PER_BLOCK);
	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int WAY_W  = $clog2(NUM_WAYS);
	localparam int OFS_W  = 2 + WORD_W;
	localparam int TAG_W  = ADDR_W - OFS_W - SET_W;

	typedef logic [31:0]       data_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [SET_W-1:0]  set_t;
	typedef logic [WAY_W-1:0]  way_t;
	typedef logic [WORD_W-1:0] wsel_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_STORE = 1'b1
	} cmd_t;

	// one memory row holds every way of a set
	typedef struct packed {
		tag_t  [NUM_WAYS-1:0]                        tag;
		data_t [NUM_WAYS-1:0][WORDS_PER_BLOCK-1:0]  data;
	} row_t;

endpackage

`default_nettype wire

// File: rtl/core/slc_req_if.sv
// request channel: one word access with the fill words of its block
`timescale 1ns / 1ps
`default_nettype none

interface slc_req_if;
	logic  valid;
	logic  ready;
	logic  command;
	logic  [31:0] address;
	logic  [31:0] store_data;
	logic  [31:0] fill_word_0;
	logic  [31:0] fill_word_1;

	modport source (output valid, command, address, store_data, fill_word_0, fill_word_1,
		input ready);
	modport sink (input valid, command, address, store_data, fill_word_0, fill_word_1,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/slc_rsp_if.sv
// response channel: access result and dirty victim write-back
`timescale 1ns / 1ps
`default_nettype none

interface slc_rsp_if;
	logic  valid;
	logic  ready;
	logic  hit;
	logic  [31:0] access_word;
	logic  writeback_valid;
	logic  [31:0] writeback_address;
	logic  [31:0] writeback_word_0;
	logic  [31:0] writeback_word_1;

	modport source (output valid, hit, access_word, writeback_valid, writeback_address,
		writeback_word_0, writeback_word_1, input ready);
	modport sink (input valid, hit, access_word, writeback_valid, writeback_address,
		writeback_word_0, writeback_word_1, output ready);
endinterface

`default_nettype wire

// File: rtl/core/set_assoc_lru_writeback_cache.sv
// four-way set-associative write-back cache with lru replacement
// result: registered after the look-up, later while the last result waits
// one access at a time: the tag/data memory row is read at the transfer,
//   then modified and written back; only after that is the next access taken
// reset: valid and dirty bits cleared, recency order per set reset to ways 0..3;
//   tag and data memory are not cleared, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_writeback_cache (
	input  wire          clk,
	input  wire          arst_n,
	slc_req_if.sink      req,
	slc_rsp_if.source    rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	state_t state_q;

	// tag and data memory, one row per set
	slc_pkg::row_t mem [slc_pkg::NUM_SETS];
	slc_pkg::row_t rd_row_q;

	logic [slc_pkg::NUM_SETS-1:0][slc_pkg::NUM_WAYS-1:0] valid_q;
	logic [slc_pkg::NUM_SETS-1:0][slc_pkg::NUM_WAYS-1:0] dirty_q;
	slc_pkg::way_t [slc_pkg::NUM_SETS-1:0][slc_pkg::NUM_WAYS-1:0] lru_q;

	// request held for the look-up cycle
	logic          cmd_s1;
	slc_pkg::tag_t tag_s1;
	slc_pkg::set_t set_s1;
	slc_pkg::wsel_t word_s1;
	slc_pkg::data_t sdata_s1;
	slc_pkg::data_t [1:0] fill_s1;

	// output register
	logic           out_valid_q;
	logic           hit_q;
	slc_pkg::data_t rdata_q;
	logic           wb_q;
	slc_pkg::data_t wb_addr_q;
	slc_pkg::data_t wb0_q;
	slc_pkg::data_t wb1_q;

	logic req_xfer;
	logic rsp_xfer;
	logic finish;
	slc_pkg::set_t req_set;

	logic           hit;
	slc_pkg::way_t  hit_way;
	logic           free_found;
	slc_pkg::way_t  free_way;
	slc_pkg::way_t  vict_way;
	slc_pkg::way_t  way_sel;
	logic           wb;
	slc_pkg::data_t wb_addr;
	slc_pkg::data_t wb0;
	slc_pkg::data_t wb1;
	slc_pkg::row_t  new_row;
	slc_pkg::data_t rdata;
	logic           new_dirty;
	slc_pkg::way_t [slc_pkg::NUM_WAYS-1:0] new_order;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp_xfer  = rsp.valid && rsp.ready;
	assign req_set   = req.address[slc_pkg::OFS_W +: slc_pkg::SET_W];
	// the look-up cycle waits while the previous result is still held
	assign finish    = (state_q == ST_LOOK) && (!out_valid_q || rsp.ready);

	always_comb begin
		slc_pkg::way_t [slc_pkg::NUM_WAYS-1:0] order;
		logic moved;
		hit        = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int w = 0; w < slc_pkg::NUM_WAYS; w++) begin
			if (!hit && valid_q[set_s1][w] && rd_row_q.tag[w] == tag_s1) begin
				hit     = 1'b1;
				hit_way = slc_pkg::way_t'(w);
			end
			if (!free_found && !valid_q[set_s1][w]) begin
				free_found = 1'b1;
				free_way   = slc_pkg::way_t'(w);
			end
		end
		vict_way = lru_q[set_s1][0];
		way_sel  = hit ? hit_way : (free_found ? free_way : vict_way);

		wb      = !hit && !free_found && dirty_q[set_s1][vict_way];
		wb_addr = '0;
		wb0     = '0;
		wb1     = '0;
		if (wb) begin
			wb_addr = {rd_row_q.tag[vict_way], set_s1, {slc_pkg::OFS_W{1'b0}}};
			wb0     = rd_row_q.data[vict_way][0];
			if (slc_pkg::WORDS_PER_BLOCK > 1) begin
				wb1 = rd_row_q.data[vict_way][slc_pkg::WORDS_PER_BLOCK-1];
			end
		end

		new_row = rd_row_q;
		if (!hit) begin
			new_row.tag[way_sel] = tag_s1;
			for (int k = 0; k < slc_pkg::WORDS_PER_BLOCK; k++) begin
				new_row.data[way_sel][k] = fill_s1[k % 2];
			end
		end
		if (cmd_s1 == slc_pkg::CMD_STORE) begin
			new_row.data[way_sel][word_s1] = sdata_s1;
			rdata = sdata_s1;
		end else begin
			rdata = new_row.data[way_sel][word_s1];
		end
		new_dirty = (cmd_s1 == slc_pkg::CMD_STORE) || (hit && dirty_q[set_s1][way_sel]);

		// shift the ways above the used one down, used way goes to the top
		order = lru_q[set_s1];
		moved = 1'b0;
		for (int i = 0; i < slc_pkg::NUM_WAYS - 1; i++) begin
			if (order[i] == way_sel) begin
				moved = 1'b1;
			end
			new_order[i] = moved ? order[i+1] : order[i];
		end
		new_order[slc_pkg::NUM_WAYS-1] = way_sel;
	end

	// reads only at request transfer, writes only in the look-up cycle: no overlap
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			rd_row_q <= mem[req_set];
		end
		if (finish) begin
			mem[set_s1] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_s1     <= req.command;
			tag_s1     <= req.address[slc_pkg::ADDR_W-1 -: slc_pkg::TAG_W];
			set_s1     <= req_set;
			word_s1    <= req.address[2 +: slc_pkg::WORD_W];
			sdata_s1   <= req.store_data;
			fill_s1[0] <= req.fill_word_0;
			fill_s1[1] <= req.fill_word_1;
		end
		if (finish) begin
			hit_q     <= hit;
			rdata_q   <= rdata;
			wb_q      <= wb;
			wb_addr_q <= wb_addr;
			wb0_q     <= wb0;
			wb1_q     <= wb1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			dirty_q     <= '0;
			for (int s = 0; s < slc_pkg::NUM_SETS; s++) begin
				for (int w = 0; w < slc_pkg::NUM_WAYS; w++) begin
					lru_q[s][w] <= slc_pkg::way_t'(w);
				end
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q               <= 1'b1;
				valid_q[set_s1][way_sel]  <= 1'b1;
				dirty_q[set_s1][way_sel]  <= new_dirty;
				lru_q[set_s1]             <= new_order;
			end else if (rsp_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.hit               = hit_q;
	assign rsp.access_word       = rdata_q;
	assign rsp.writeback_valid   = wb_q;
	assign rsp.writeback_address = wb_addr_q;
	assign rsp.writeback_word_0  = wb0_q;
	assign rsp.writeback_word_1  = wb1_q;

	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> state_q == ST_LOOK)
		else $error("accepted request did not enter look-up");

	a_no_accept_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> !req.ready)
		else $error("request accepted during look-up");

	a_wb_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.writeback_valid))
		else $error("write-back reported on a hit");

	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(valid_q) >= $countones($past(valid_q)))
		else $error("valid bit lost");

	a_finish_sets_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp.valid)
		else $error("finished access produced no result");

endmodule

`default_nettype wire

// File: dv/set_assoc_lru_writeback_cache_tb.sv
// testbench of the four-way lru write-back cache: predicted access results and write-backs
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_tb;

	localparam int unsigned BLOCK_BYTES = 4 * slc_pkg::WORDS_PER_BLOCK;
	localparam int HOT_BLOCKS = 12;

	typedef struct {
		slc_pkg::cmd_t  command;
		slc_pkg::data_t address;
		slc_pkg::data_t store_data;
		slc_pkg::data_t fill_word_0;
		slc_pkg::data_t fill_word_1;
	} access_t;

	typedef struct {
		logic           hit;
		slc_pkg::data_t access_word;
		logic           writeback_valid;
		slc_pkg::data_t writeback_address;
		slc_pkg::data_t writeback_word_0;
		slc_pkg::data_t writeback_word_1;
	} outcome_t;

	logic clk;
	logic arst_n;

	slc_req_if req ();
	slc_rsp_if rsp ();

	set_assoc_lru_writeback_cache dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// predicted cache contents
	slc_pkg::tag_t  tag_mem   [slc_pkg::NUM_SETS][slc_pkg::NUM_WAYS];
	bit             line_valid[slc_pkg::NUM_SETS][slc_pkg::NUM_WAYS];
	bit             line_dirty[slc_pkg::NUM_SETS][slc_pkg::NUM_WAYS];
	slc_pkg::data_t line_data [slc_pkg::NUM_SETS][slc_pkg::NUM_WAYS][slc_pkg::WORDS_PER_BLOCK];
	slc_pkg::way_t  lru_order [slc_pkg::NUM_SETS][slc_pkg::NUM_WAYS];

	outcome_t       pending_outcomes[$];
	int             error_count;
	bit             src_gaps_on;
	bit             sink_stalls_on;
	int             stall_left;
	slc_pkg::data_t hot_blocks[HOT_BLOCKS];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic outcome_t predict_access(access_t a);
		int unsigned    blk;
		int unsigned    set_idx;
		int unsigned    word_idx;
		int unsigned    way_idx;
		slc_pkg::tag_t  tag;
		bit             found;
		bit             moved;
		slc_pkg::data_t fill[2];
		outcome_t       r;
		r = '{default: '0};
		blk = a.address / BLOCK_BYTES;
		set_idx = blk % slc_pkg::NUM_SETS;
		tag = slc_pkg::tag_t'(blk / slc_pkg::NUM_SETS);
		word_idx = (a.address >> 2) % slc_pkg::WORDS_PER_BLOCK;
		fill[0] = a.fill_word_0;
		fill[1] = a.fill_word_1;
		found = 1'b0;
		way_idx = 0;
		for (int w = 0; w < slc_pkg::NUM_WAYS; w++) begin
			if (!found && line_valid[set_idx][w] && tag_mem[set_idx][w] == tag) begin
				found = 1'b1;
				way_idx = w;
			end
		end
		r.hit = found;
		if (!found) begin
			for (int w = 0; w < slc_pkg::NUM_WAYS; w++) begin
				if (!found && !line_valid[set_idx][w]) begin
					found = 1'b1;
					way_idx = w;
				end
			end
			if (!found) begin
				way_idx = lru_order[set_idx][0];
				if (line_dirty[set_idx][way_idx]) begin
					r.writeback_valid = 1'b1;
					r.writeback_address = (32'(tag_mem[set_idx][way_idx]) * slc_pkg::NUM_SETS
						+ set_idx) * BLOCK_BYTES;
					r.writeback_word_0 = line_data[set_idx][way_idx][0];
					if (slc_pkg::WORDS_PER_BLOCK > 1)
						r.writeback_word_1 =
							line_data[set_idx][way_idx][slc_pkg::WORDS_PER_BLOCK-1];
				end
			end
			for (int k = 0; k < slc_pkg::WORDS_PER_BLOCK; k++)
				line_data[set_idx][way_idx][k] = fill[k & 1];
			tag_mem[set_idx][way_idx] = tag;
			line_valid[set_idx][way_idx] = 1'b1;
			line_dirty[set_idx][way_idx] = 1'b0;
		end
		if (a.command == slc_pkg::CMD_STORE) begin
			line_data[set_idx][way_idx][word_idx] = a.store_data;
			line_dirty[set_idx][way_idx] = 1'b1;
			r.access_word = a.store_data;
		end else begin
			r.access_word = line_data[set_idx][way_idx][word_idx];
		end
		// shift the ways above the touched one down, touched way goes to most recent
		moved = 1'b0;
		for (int i = 0; i < slc_pkg::NUM_WAYS - 1; i++) begin
			if (lru_order[set_idx][i] == slc_pkg::way_t'(way_idx))
				moved = 1'b1;
			if (moved)
				lru_order[set_idx][i] = lru_order[set_idx][i+1];
		end
		lru_order[set_idx][slc_pkg::NUM_WAYS-1] = slc_pkg::way_t'(way_idx);
		return r;
	endfunction

	function automatic int idle_cycles();
		int r;
		if (!src_gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly a small pool of blocks so that hits, refills and dirty evictions all happen
	function automatic access_t random_access();
		access_t a;
		if ($urandom_range(0, 19) == 0)
			hot_blocks[$urandom_range(0, HOT_BLOCKS-1)] = $urandom & ~32'h7;
		if ($urandom_range(0, 6) == 0)
			a.address = $urandom;
		else
			a.address = hot_blocks[$urandom_range(0, HOT_BLOCKS-1)] | $urandom_range(0, 7);
		a.command = slc_pkg::cmd_t'($urandom_range(0, 1));
		a.store_data = $urandom;
		a.fill_word_0 = $urandom;
		a.fill_word_1 = $urandom;
		return a;
	endfunction

	// leaves valid high after the transfer; the caller or a gap in the next call lowers it
	task automatic send_access(access_t a);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= a.command;
		req.address <= a.address;
		req.store_data <= a.store_data;
		req.fill_word_0 <= a.fill_word_0;
		req.fill_word_1 <= a.fill_word_1;
		do @(posedge clk); while (!req.ready);
		pending_outcomes.push_back(predict_access(a));
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
		end
	endfunction

	always @(posedge clk) begin
		outcome_t exp;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_outcomes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual hit %b data %h",
					$time, rsp.hit, rsp.access_word);
			end else begin
				exp = pending_outcomes.pop_front();
				check_field("hit", 32'(exp.hit), 32'(rsp.hit));
				check_field("access_word", exp.access_word, rsp.access_word);
				check_field("writeback_valid", 32'(exp.writeback_valid),
					32'(rsp.writeback_valid));
				check_field("writeback_address", exp.writeback_address, rsp.writeback_address);
				check_field("writeback_word_0", exp.writeback_word_0, rsp.writeback_word_0);
				check_field("writeback_word_1", exp.writeback_word_1, rsp.writeback_word_1);
			end
		end
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
			rsp.ready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// set 0: fill all ways, hit on both words, then evict dirty and clean victims
	task automatic test_set0_fill_hit_evict();
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_0000, 32'h0000_0000,
			32'hffff_ffff, 32'h0000_0000});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h4000_0004, 32'hffff_ffff,
			32'h0000_0000, 32'hffff_ffff});
		send_access(access_t'{slc_pkg::CMD_STORE, 32'h8000_0000, 32'ha5a5_a5a5,
			32'h1111_1111, 32'h2222_2222});
		send_access(access_t'{slc_pkg::CMD_STORE, 32'hc000_0007, 32'hffff_ffff,
			32'h3333_3333, 32'h4444_4444});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_0004, 32'h0,
			32'h5555_5555, 32'h6666_6666});
		send_access(access_t'{slc_pkg::CMD_STORE, 32'h4000_0000, 32'h0000_0000,
			32'h7777_7777, 32'h8888_8888});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h8000_0000, 32'h0,
			32'h9999_9999, 32'haaaa_aaaa});
		// way 3 is least recent and dirty
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_0010, 32'h0,
			32'hdead_beef, 32'hcafe_f00d});
		// way 0 is clean, no write-back
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_0020, 32'h0,
			32'h0123_4567, 32'h89ab_cdef});
		send_access(access_t'{slc_pkg::CMD_STORE, 32'h0000_0032, 32'h5a5a_5a5a,
			32'hfedc_ba98, 32'h7654_3210});
	endtask

	// set 1 with all-ones tag and byte offsets, evicted later at address 0xfffffff8
	task automatic test_set1_extreme_addresses();
		send_access(access_t'{slc_pkg::CMD_STORE, 32'hffff_ffff, 32'h0000_0001,
			32'hffff_fffe, 32'h8000_0000});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'hffff_fffb, 32'h0, 32'h0, 32'h0});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_000c, 32'hffff_ffff,
			32'h8000_0001, 32'h7fff_ffff});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h7fff_fff8, 32'h0,
			32'h1357_9bdf, 32'h2468_ace0});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_002c, 32'h0,
			32'hffff_ffff, 32'hffff_ffff});
		send_access(access_t'{slc_pkg::CMD_STORE, 32'h0000_003d, 32'hffff_ffff,
			32'h0, 32'h0});
		send_access(access_t'{slc_pkg::CMD_LOAD, 32'h0000_004e, 32'h0,
			32'h0f0f_0f0f, 32'hf0f0_f0f0});
	endtask

	task automatic test_back_to_back_traffic(int count);
		src_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		repeat (count) send_access(random_access());
	endtask

	task automatic test_stalled_traffic(int count);
		src_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		repeat (count) send_access(random_access());
	endtask

	// sender holds off until every pending result is back, then resumes
	task automatic test_pause_until_drained(int rounds, int count);
		repeat (rounds) begin
			src_gaps_on = $urandom_range(0, 1);
			sink_stalls_on = 1'b1;
			repeat (count) send_access(random_access());
			wait_drained();
		end
	endtask

	initial begin
		error_count = 0;
		stall_left = 0;
		src_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		for (int s = 0; s < slc_pkg::NUM_SETS; s++) begin
			for (int w = 0; w < slc_pkg::NUM_WAYS; w++) begin
				tag_mem[s][w] = '0;
				line_valid[s][w] = 1'b0;
				line_dirty[s][w] = 1'b0;
				lru_order[s][w] = slc_pkg::way_t'(w);
				for (int k = 0; k < slc_pkg::WORDS_PER_BLOCK; k++)
					line_data[s][w][k] = '0;
			end
		end
		foreach (hot_blocks[i])
			hot_blocks[i] = $urandom & ~32'h7;
		arst_n = 1'b0;
		rsp.ready = 1'b0;
		req.valid = 1'b0;
		req.command = slc_pkg::CMD_LOAD;
		req.address = '0;
		req.store_data = '0;
		req.fill_word_0 = '0;
		req.fill_word_1 = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_set0_fill_hit_evict();
		test_set1_extreme_addresses();
		test_back_to_back_traffic(300);
		test_stalled_traffic(300);
		test_pause_until_drained(4, 100);

		req.valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: set_assoc_lru_writeback_cache.f
rtl/core/slc_pkg.sv
rtl/core/slc_req_if.sv
rtl/core/slc_rsp_if.sv
rtl/core/set_assoc_lru_writeback_cache.sv
dv/set_assoc_lru_writeback_cache_tb.sv
